/* src/csbs_pkg.sv */
// Package for the CPU subset bus sequencer.
// Holds the decode phases, the opcodes, the flag positions and the reset constants.
// No dependencies.
package csbs_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_FETCH = 3'd1,
      PH_OPER1 = 3'd2,
      PH_OPER2 = 3'd3,
      PH_LOADA = 3'd4,
      PH_WROTE = 3'd5,
      PH_POPLO = 3'd6,
      PH_POPHI = 3'd7
   } phase_type;

   localparam logic [7:0] OP_NOP  = 8'h00;
   localparam logic [7:0] OP_JP   = 8'hC3;
   localparam logic [7:0] OP_LDH_A = 8'hF0;
   localparam logic [7:0] OP_LDH_M = 8'hE0;
   localparam logic [7:0] OP_CP   = 8'hFE;
   localparam logic [7:0] OP_RETZ = 8'hC8;

   localparam int FL_Z = 3;
   localparam int FL_N = 2;
   localparam int FL_H = 1;
   localparam int FL_C = 0;

   localparam logic [15:0] START_ADDRESS_RESET = 16'h0100;
   localparam logic [15:0] STACK_START_RESET   = 16'hFFFE;
   localparam logic [7:0]  ACC_RESET           = 8'h01;
   localparam logic [3:0]  FLAG_RESET          = 4'hB;
   localparam logic [7:0]  HIGH_PAGE           = 8'hFF;

   localparam logic [7:0] CSR_START_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_STACK_START   = 8'd1;

   localparam int RSP_DATA_W = 40;

   // One bus access as it leaves the block.
   typedef struct packed {
      logic [15:0] bus_address;
      logic        bus_write;
      logic [7:0]  bus_write_data;
      logic        halted;
      logic [7:0]  acc_value;
      logic [3:0]  flag_bits;
   } access_type;

endpackage

/* src/cpu_subset_bus_sequencer.sv */
// CPU subset bus sequencer: decode, execute and next-access logic with an output skid pair.
// Depends on csbs_pkg.
//
// Usage: every item on the req_ channel completes the bus access that the
// previous rsp_ item described and carries its read byte in req_tdata. Each
// accepted item yields exactly one rsp_ item naming the next access (address,
// direction, write byte) together with the halt status, accumulator and flags.
// The first item after reset only triggers the first opcode fetch.
// The result is registered at the edge that accepts the item. Throughput is one
// item per cycle while req_tready is high; the decode step from the phase
// register and the read byte to the next state is the only logic per item.
// A two-entry output (result register plus skid register) lets an item be
// accepted while a result still waits; req_tready falls whenever the skid
// register holds a result.
// Reset (synchronous) loads the program counter and stack pointer from the
// start registers' reset values, clears the phase and halt, and empties the
// output. The csr_ channel is always ready; writing the start address or the
// stack start also loads the program counter or stack pointer.
// After an unknown opcode every result reads as no access with halted set.
module cpu_subset_bus_sequencer
   import csbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] read_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] bus_address, [23:16] bus_write_data, [24] halted,
   // [32:25] acc_value, [36:33] flag_bits, [39:37] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] bus_write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] start_ff, start_in;
   logic [15:0] stack_start_ff, stack_start_in;
   logic [15:0] pc_ff, pc_in;
   logic [15:0] sp_ff, sp_in;
   logic [7:0]  acc_ff, acc_in;
   logic [3:0]  flag_ff, flag_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  low_ff, low_in;
   logic        stop_ff, stop_in;

   access_type  out_ff, skid_ff, result;
   logic        out_valid_ff, skid_valid_ff;

   logic        req_fire, rsp_fire, csr_fire;
   logic [15:0] emit_addr;
   logic        emit_wr;
   logic [7:0]  d;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign d          = req_tdata;

   // Next state and next access for one accepted item.
   always_comb begin
      start_in       = start_ff;
      stack_start_in = stack_start_ff;
      pc_in          = pc_ff;
      sp_in          = sp_ff;
      acc_in         = acc_ff;
      flag_in        = flag_ff;
      phase_in       = phase_ff;
      opcode_in      = opcode_ff;
      low_in         = low_ff;
      stop_in        = stop_ff;
      emit_addr      = 16'h0000;
      emit_wr        = 1'b0;

      if (req_fire && !stop_ff) begin
         unique case (phase_ff)
            PH_START: begin
               phase_in  = PH_FETCH;
               emit_addr = pc_ff;
            end
            PH_FETCH: begin
               opcode_in = d;
               pc_in     = pc_ff + 16'd1;
               if (d == OP_NOP) begin
                  phase_in  = PH_FETCH;
                  emit_addr = pc_in;
               end else if (d == OP_JP || d == OP_LDH_A || d == OP_CP || d == OP_LDH_M) begin
                  phase_in  = PH_OPER1;
                  emit_addr = pc_in;
               end else if (d == OP_RETZ) begin
                  if (flag_ff[FL_Z]) begin
                     phase_in  = PH_POPLO;
                     emit_addr = sp_ff;
                  end else begin
                     phase_in  = PH_FETCH;
                     emit_addr = pc_in;
                  end
               end else begin
                  stop_in = 1'b1;
               end
            end
            PH_OPER1: begin
               pc_in = pc_ff + 16'd1;
               if (opcode_ff == OP_JP) begin
                  low_in    = d;
                  phase_in  = PH_OPER2;
                  emit_addr = pc_in;
               end else if (opcode_ff == OP_LDH_A) begin
                  phase_in  = PH_LOADA;
                  emit_addr = {HIGH_PAGE, d};
               end else if (opcode_ff == OP_LDH_M) begin
                  phase_in  = PH_WROTE;
                  emit_addr = {HIGH_PAGE, d};
                  emit_wr   = 1'b1;
               end else begin
                  flag_in        = 4'h0;
                  flag_in[FL_N]  = 1'b1;
                  flag_in[FL_Z]  = (acc_ff == d);
                  flag_in[FL_H]  = (acc_ff[3:0] < d[3:0]);
                  flag_in[FL_C]  = (acc_ff < d);
                  phase_in       = PH_FETCH;
                  emit_addr      = pc_in;
               end
            end
            PH_OPER2: begin
               pc_in     = {d, low_ff};
               phase_in  = PH_FETCH;
               emit_addr = pc_in;
            end
            PH_LOADA: begin
               acc_in    = d;
               phase_in  = PH_FETCH;
               emit_addr = pc_ff;
            end
            PH_WROTE: begin
               phase_in  = PH_FETCH;
               emit_addr = pc_ff;
            end
            PH_POPLO: begin
               low_in    = d;
               sp_in     = sp_ff + 16'd1;
               phase_in  = PH_POPHI;
               emit_addr = sp_in;
            end
            PH_POPHI: begin
               sp_in     = sp_ff + 16'd1;
               pc_in     = {d, low_ff};
               phase_in  = PH_FETCH;
               emit_addr = pc_in;
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end

      // The user must write configuration only while no item is in flight; the block does not enforce it.
      if (csr_fire) begin
         if (csr_index == CSR_START_ADDRESS) begin
            start_in = csr_data;
            pc_in    = csr_data;
         end else if (csr_index == CSR_STACK_START) begin
            stack_start_in = csr_data;
            sp_in          = csr_data;
         end
      end

      result.bus_address    = stop_in ? 16'h0000 : emit_addr;
      result.bus_write      = stop_in ? 1'b0 : emit_wr;
      result.bus_write_data = (emit_wr && !stop_in) ? acc_ff : 8'h00;
      result.halted         = stop_in;
      result.acc_value      = acc_in;
      result.flag_bits      = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff       <= START_ADDRESS_RESET;
         stack_start_ff <= STACK_START_RESET;
         pc_ff          <= START_ADDRESS_RESET;
         sp_ff          <= STACK_START_RESET;
         acc_ff         <= ACC_RESET;
         flag_ff        <= FLAG_RESET;
         phase_ff       <= PH_START;
         opcode_ff      <= 8'h00;
         low_ff         <= 8'h00;
         stop_ff        <= 1'b0;
      end else begin
         start_ff       <= start_in;
         stack_start_ff <= stack_start_in;
         pc_ff          <= pc_in;
         sp_ff          <= sp_in;
         acc_ff         <= acc_in;
         flag_ff        <= flag_in;
         phase_ff       <= phase_in;
         opcode_ff      <= opcode_in;
         low_ff         <= low_in;
         stop_ff        <= stop_in;
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_fire) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= result;
               out_valid_ff <= req_fire;
            end
         end else if (req_fire) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.bus_write;
   assign rsp_tdata  = {3'b000, out_ff.flag_bits, out_ff.acc_value, out_ff.halted,
                        out_ff.bus_write_data, out_ff.bus_address};

   // A halted result never describes an access.
   a_halt_no_access: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.halted) |-> (out_ff.bus_address == 16'h0000 && !rsp_tuser))
      else $error("halted result carries a bus access");

   // The skid register is only occupied behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the output is empty");

   // Halt is sticky until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff |=> stop_ff)
      else $error("halt cleared without reset");

   // A write access always follows the operand of a high-page store.
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit_wr && !stop_in) |=> (phase_ff == PH_WROTE))
      else $error("write issued outside the store sequence");

endmodule
